>>> rtl/core/glprs_pkg.sv
// ----------------------------------------------------------------------------
// glprs_pkg
// Shared types and constants for the grid low point risk sum block.
// ----------------------------------------------------------------------------
package glprs_pkg;

   localparam int ROW_WIDTH_BITS = 8;
   localparam int SUM_BITS       = 32;

   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 8'd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ITEM_RIGHT,
      ST_ITEM_JUDGE,
      ST_FLUSH_CENTRE,
      ST_FLUSH_RIGHT,
      ST_FLUSH_JUDGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic read_centre;
      logic read_right;
      logic use_flush;
      logic judge_item;
      logic judge_flush;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_cell;
      logic flush_end;
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> rtl/core/glprs_ram.sv
// ----------------------------------------------------------------------------
// glprs_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module glprs_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/glprs_ctrl.sv
// ----------------------------------------------------------------------------
// glprs_ctrl
// Sequencer for item decisions and the end-of-frame flush walk.
// ----------------------------------------------------------------------------
module glprs_ctrl
   import glprs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept      = 1'b1;
               cmd.read_centre = 1'b1;
               state_in        = ST_ITEM_RIGHT;
            end
         end
         ST_ITEM_RIGHT: begin
            cmd.read_right = 1'b1;
            state_in       = ST_ITEM_JUDGE;
         end
         ST_ITEM_JUDGE: begin
            cmd.judge_item = 1'b1;
            state_in       = status.last_cell ? ST_FLUSH_CENTRE : ST_IDLE;
         end
         ST_FLUSH_CENTRE: begin
            cmd.use_flush   = 1'b1;
            cmd.read_centre = 1'b1;
            state_in        = ST_FLUSH_RIGHT;
         end
         ST_FLUSH_RIGHT: begin
            cmd.use_flush  = 1'b1;
            cmd.read_right = 1'b1;
            state_in       = ST_FLUSH_JUDGE;
         end
         ST_FLUSH_JUDGE: begin
            cmd.use_flush   = 1'b1;
            cmd.judge_flush = 1'b1;
            state_in        = status.flush_end ? ST_EMIT : ST_FLUSH_CENTRE;
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/glprs_datapath.sv
// ----------------------------------------------------------------------------
// glprs_datapath
// Line buffers, neighbour compare, saturating sums and result word register.
// ----------------------------------------------------------------------------
module glprs_datapath
   import glprs_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 128,
   parameter int HEIGHT_BITS   = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ROW_WIDTH_BITS-1:0] csr_wr_data,
   input  logic [HEIGHT_BITS-1:0]    req_height,
   input  logic                      req_last_cell,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [SUM_BITS-1:0]       rsp_risk_sum,
   output logic [SUM_BITS-1:0]       rsp_low_point_count,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status
);

   localparam int IDX_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
   localparam int WW    = $clog2(MAX_ROW_WIDTH + 1);
   localparam int CW    = (WW > ROW_WIDTH_BITS) ? WW : ROW_WIDTH_BITS;
   localparam int PW    = (IDX_W + 1 > WW) ? IDX_W + 1 : WW;

   // control and frame state
   logic [ROW_WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic [IDX_W-1:0]          col_ff, col_in;
   logic [1:0]                rows_ff, rows_in;
   logic [SUM_BITS-1:0]       acc_ff, acc_in;
   logic [SUM_BITS-1:0]       tally_ff, tally_in;
   logic [HEIGHT_BITS-1:0]    left_ff, left_in;
   logic [MAX_ROW_WIDTH-1:0]  mvalid_ff, mvalid_in;
   logic [MAX_ROW_WIDTH-1:0]  uvalid_ff, uvalid_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [HEIGHT_BITS-1:0]    height_ff, height_in;
   logic                      last_ff, last_in;
   logic [WW-1:0]             width_ff, width_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic                      part_a_ff, part_a_in;
   logic [HEIGHT_BITS-1:0]    centre_ff, centre_in;
   logic [HEIGHT_BITS-1:0]    upper_ff, upper_in;
   logic [SUM_BITS-1:0]       rsp_sum_ff, rsp_sum_in;
   logic [SUM_BITS-1:0]       rsp_count_ff, rsp_count_in;

   logic [CW-1:0]          csr_ext;
   logic [WW-1:0]          eff_width;
   logic [IDX_W-1:0]       addr;
   logic [IDX_W:0]         addr_next_wide;
   logic [IDX_W-1:0]       addr_next;
   logic                   right_in_range;
   logic [IDX_W-1:0]       mid_rd_addr;
   logic [HEIGHT_BITS-1:0] mid_rd_data;
   logic [HEIGHT_BITS-1:0] up_rd_data;
   logic [HEIGHT_BITS-1:0] centre_val;
   logic [HEIGHT_BITS-1:0] upper_val;
   logic [HEIGHT_BITS-1:0] right_val;
   logic [PW-1:0]          pos_w;
   logic [PW-1:0]          pos_a1;
   logic                   right_exists;
   logic                   hu, hd, hl, hr;
   logic                   judge_en;
   logic                   is_low;
   logic [SUM_BITS:0]      sum_wide;

   // effective row width
   always_comb begin
      csr_ext = CW'(row_width_ff);
      if (csr_ext == '0) begin
         eff_width = WW'(1);
      end else if (csr_ext > CW'(MAX_ROW_WIDTH)) begin
         eff_width = WW'(MAX_ROW_WIDTH);
      end else begin
         eff_width = WW'(csr_ext);
      end
   end

   assign addr           = cmd.use_flush ? k_ff : col_ff;
   assign addr_next_wide = {1'b0, addr} + (IDX_W + 1)'(1);
   assign addr_next      = addr_next_wide[IDX_W-1:0];
   assign right_in_range = addr_next_wide < (IDX_W + 1)'(MAX_ROW_WIDTH);
   assign mid_rd_addr    = cmd.read_right ? addr_next : addr;

   glprs_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (MAX_ROW_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (cmd.judge_item),
      .wr_addr (col_ff),
      .wr_data (height_ff),
      .rd_en   (cmd.read_centre | cmd.read_right),
      .rd_addr (mid_rd_addr),
      .rd_data (mid_rd_data)
   );

   glprs_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (MAX_ROW_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (cmd.judge_item),
      .wr_addr (col_ff),
      .wr_data (centre_ff),
      .rd_en   (cmd.read_centre),
      .rd_addr (addr),
      .rd_data (up_rd_data)
   );

   // unwritten entries read as zero
   assign centre_val = mvalid_ff[addr] ? mid_rd_data : '0;
   assign upper_val  = uvalid_ff[addr] ? up_rd_data : '0;
   assign right_val  = (right_in_range && mvalid_ff[addr_next]) ? mid_rd_data : '0;

   assign pos_w        = PW'(width_ff);
   assign pos_a1       = PW'(addr) + PW'(1);
   assign right_exists = pos_a1 < pos_w;

   // neighbour presence
   always_comb begin
      hd = 1'b0;
      if (cmd.judge_item) begin
         hu = (rows_ff == 2'd2);
         hd = 1'b1;
         hl = (col_ff != '0);
         hr = right_exists;
      end else if (part_a_ff) begin
         hu = (rows_ff == 2'd2);
         hl = 1'b1;
         hr = right_exists;
      end else begin
         hu = (rows_ff != 2'd0);
         hl = (k_ff != '0);
         hr = (k_ff < col_ff);
      end
   end

   assign judge_en = (cmd.judge_item && (rows_ff != 2'd0)) || cmd.judge_flush;
   assign is_low   = (!hu || (centre_ff < upper_ff)) &&
                     (!hd || (centre_ff < height_ff)) &&
                     (!hl || (centre_ff < left_ff)) &&
                     (!hr || (centre_ff < right_val));
   assign sum_wide = {1'b0, acc_ff} + (SUM_BITS + 1)'(centre_ff) + (SUM_BITS + 1)'(1);

   always_comb begin
      row_width_in = row_width_ff;
      col_in       = col_ff;
      rows_in      = rows_ff;
      acc_in       = acc_ff;
      tally_in     = tally_ff;
      left_in      = left_ff;
      mvalid_in    = mvalid_ff;
      uvalid_in    = uvalid_ff;
      rsp_valid_in = rsp_valid_ff;
      height_in    = height_ff;
      last_in      = last_ff;
      width_in     = width_ff;
      k_in         = k_ff;
      part_a_in    = part_a_ff;
      centre_in    = centre_ff;
      upper_in     = upper_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;

      if (csr_wr_en) begin
         row_width_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         height_in = req_height;
         last_in   = req_last_cell;
         width_in  = eff_width;
      end

      if (cmd.read_right) begin
         centre_in = centre_val;
         upper_in  = upper_val;
      end

      if (judge_en && is_low) begin
         acc_in   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
         tally_in = (&tally_ff) ? tally_ff : tally_ff + SUM_BITS'(1);
      end

      if (cmd.judge_item) begin
         left_in           = centre_ff;
         mvalid_in[col_ff] = 1'b1;
         uvalid_in[col_ff] = 1'b1;
         if (last_ff) begin
            if ((rows_ff != 2'd0) && right_exists) begin
               k_in      = addr_next;
               part_a_in = 1'b1;
            end else begin
               k_in      = '0;
               part_a_in = 1'b0;
            end
         end else if (!right_exists) begin
            col_in = '0;
            if (rows_ff != 2'd2) begin
               rows_in = rows_ff + 2'd1;
            end
         end else begin
            col_in = addr_next;
         end
      end

      if (cmd.judge_flush) begin
         left_in = centre_ff;
         if (part_a_ff) begin
            if (right_exists) begin
               k_in = addr_next;
            end else begin
               k_in      = '0;
               part_a_in = 1'b0;
            end
         end else if (k_ff != col_ff) begin
            k_in = addr_next;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = acc_ff;
         rsp_count_in = tally_ff;
         col_in       = '0;
         rows_in      = 2'd0;
         acc_in       = '0;
         tally_in     = '0;
         left_in      = '0;
         mvalid_in    = '0;
         uvalid_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         col_ff       <= '0;
         rows_ff      <= 2'd0;
         acc_ff       <= '0;
         tally_ff     <= '0;
         left_ff      <= '0;
         mvalid_ff    <= '0;
         uvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         col_ff       <= col_in;
         rows_ff      <= rows_in;
         acc_ff       <= acc_in;
         tally_ff     <= tally_in;
         left_ff      <= left_in;
         mvalid_ff    <= mvalid_in;
         uvalid_ff    <= uvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      height_ff    <= height_in;
      last_ff      <= last_in;
      width_ff     <= width_in;
      k_ff         <= k_in;
      part_a_ff    <= part_a_in;
      centre_ff    <= centre_in;
      upper_ff     <= upper_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.last_cell = last_ff;
   assign status.flush_end = !part_a_ff && (k_ff == col_ff);
   assign status.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_risk_sum        = rsp_sum_ff;
   assign rsp_low_point_count = rsp_count_ff;

endmodule

>>> rtl/core/grid_low_point_risk_sum.sv
// ----------------------------------------------------------------------------
// grid_low_point_risk_sum
// Streaming 4-neighbour low point detector with saturating risk sum.
// ----------------------------------------------------------------------------
// Cells arrive on the req_ channel in row-major order, one height per word;
// req_last_cell marks the final cell of a map. The row width is set through
// csr_wr_en/csr_wr_data (0 acts as 1, values above MAX_ROW_WIDTH clamp); the
// user must write it only while the block is idle; the block does not enforce it.
// Each word passes accept, right-neighbour read and decide before the next.
// The middle line buffer has a single read port, so the centre and right
// neighbour are fetched in turn.
// The final cell then walks the open cells of the last rows (at most row width
// cells), each by centre read, right read and decide, then loads the result word.
// One rsp_ word carries the saturating risk sum and low point count; the
// frame state is then cleared and a new map may start at once.
// If rsp_stall holds, the result word waits in its register; a further
// frame may run meanwhile, held only before loading its own result.
// Synchronous reset clears the frame and sets the row width to 100.
// ----------------------------------------------------------------------------
module grid_low_point_risk_sum
   import glprs_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = 128,
   parameter int HEIGHT_BITS   = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [ROW_WIDTH_BITS-1:0] csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [HEIGHT_BITS-1:0]    req_height,
   input  logic                      req_last_cell,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [SUM_BITS-1:0]       rsp_risk_sum,
   output logic [SUM_BITS-1:0]       rsp_low_point_count
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   glprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   glprs_datapath #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
      .HEIGHT_BITS   (HEIGHT_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_height          (req_height),
      .req_last_cell       (req_last_cell),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_risk_sum        (rsp_risk_sum),
      .rsp_low_point_count (rsp_low_point_count),
      .cmd                 (cmd),
      .status              (status)
   );

   // every low point adds at least one to the sum
   a_sum_covers_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_risk_sum >= rsp_low_point_count))
      else $error("risk sum below low point count");

   // a word taken in is followed by busy cycles
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken while an item is in progress");

   // a result appears only from the load step of a flush
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result word without end of frame");

   // the result slot is never overwritten while held
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("result word overwritten while stalled");

endmodule
